>>> design/soft_timer_bank_assert.svh
// assertion macros shared by the checker
`ifndef SOFT_TIMER_BANK_ASSERT_SVH
`define SOFT_TIMER_BANK_ASSERT_SVH

// expression holds at every clock outside reset
`define STB_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("soft_timer_bank check failed");

// consequent holds in the cycle after the antecedent
`define STB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("soft_timer_bank check failed");

`endif

>>> design/stb_pkg.sv
package stb_pkg;

	localparam int NUM_TIMERS = 64;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 16;
	localparam int KIND_W     = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_ON_DELAY  = 2'd0,
		KIND_OFF_DELAY = 2'd1,
		KIND_PERIODIC  = 2'd2
	} kind_t;

	typedef struct packed {
		logic             we;
		logic [CNT_W-1:0] cnt;
		logic             out;
	} tick_res_t;

endpackage

>>> design/stb_ram.sv
module stb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/stb_tick.sv
module stb_tick (
	input  logic [stb_pkg::KIND_W-1:0] kind,
	input  logic [stb_pkg::IDX_W-1:0]  idx,
	input  logic                       level,
	input  logic [stb_pkg::CNT_W-1:0]  delay,
	input  logic [stb_pkg::CNT_W-1:0]  cur,
	output stb_pkg::tick_res_t         res
);

	logic in_range;

	always_comb begin
		in_range = ({1'b0, idx} < (stb_pkg::IDX_W + 1)'(stb_pkg::NUM_TIMERS));
		res.we   = 1'b0;
		res.cnt  = cur;
		res.out  = 1'b0;
		if (in_range) begin
			case (kind)
				stb_pkg::KIND_ON_DELAY: begin
					res.we = 1'b1;
					if (!level) begin
						res.cnt = '0;
					end else if (cur >= delay) begin
						res.out = 1'b1;
					end else begin
						res.cnt = cur + 1'b1;
					end
				end
				stb_pkg::KIND_OFF_DELAY: begin
					res.we = 1'b1;
					if (level) begin
						res.cnt = delay;
						res.out = 1'b1;
					end else if (cur != '0) begin
						res.out = 1'b1;
						if (cur < delay) begin
							res.cnt = cur - 1'b1;
						end else if (delay == '0) begin
							res.cnt = '0;
						end else begin
							res.cnt = delay - 1'b1;
						end
					end
				end
				stb_pkg::KIND_PERIODIC: begin
					res.we = 1'b1;
					if (cur != '0) begin
						res.cnt = cur - 1'b1;
					end else begin
						res.cnt = delay;
						res.out = 1'b1;
					end
				end
				default: begin
					res.we = 1'b0;
				end
			endcase
		end
	end

endmodule

>>> design/soft_timer_bank.sv
// Bank of 64 tick timers (on-delay, off-delay, periodic pulse), counts held in a
// 64 x 16 synchronous RAM. Each request names one timer and gives one result.
// The RAM is read when a request is taken. The timer is updated and written back
// when its result is loaded into the output register; that step waits while the
// result already held there is stalled. Back-to-back requests to the same timer
// are forwarded around the RAM, so one request per cycle is sustained while the
// result side keeps taking results. Reset clears a per-timer valid bit at once:
// the bank is usable the cycle after reset with no clearing pass.
module soft_timer_bank (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // timer_index[5:0], level_in[6], delay_value[22:7], zero[23]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // timer_out[0], zero[7:1]
);

	logic                      accept;
	logic                      advance;
	logic                      commit;
	logic [stb_pkg::IDX_W-1:0] in_idx;
	logic                      in_level;
	logic [stb_pkg::CNT_W-1:0] in_delay;

	logic                       vld_s1;
	logic [stb_pkg::KIND_W-1:0] kind_s1;
	logic [stb_pkg::IDX_W-1:0]  idx_s1;
	logic                       lvl_s1;
	logic [stb_pkg::CNT_W-1:0]  dly_s1;
	logic                       hit_s1;
	logic [stb_pkg::CNT_W-1:0]  fwd_s1;
	logic                       rvld_s1;

	logic [stb_pkg::NUM_TIMERS-1:0] entry_vld_q;
	logic                           out_vld_q;
	logic                           out_q;

	logic [stb_pkg::CNT_W-1:0] rd_data;
	logic [stb_pkg::CNT_W-1:0] cur_cnt;
	stb_pkg::tick_res_t        res;

	assign in_idx   = s_tdata[5:0];
	assign in_level = s_tdata[6];
	assign in_delay = s_tdata[22:7];

	assign advance  = !out_vld_q || m_tready;
	assign s_tready = !vld_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign commit   = vld_s1 && advance;

	// forwarded count wins over the stale ram read
	assign cur_cnt = hit_s1 ? fwd_s1 : (rvld_s1 ? rd_data : '0);

	stb_ram #(
		.WIDTH(stb_pkg::CNT_W),
		.DEPTH(stb_pkg::NUM_TIMERS)
	) u_ram (
		.clk  (clk),
		.we   (commit && res.we),
		.waddr(idx_s1),
		.wdata(res.cnt),
		.re   (accept),
		.raddr(in_idx),
		.rdata(rd_data)
	);

	stb_tick u_tick (
		.kind (kind_s1),
		.idx  (idx_s1),
		.level(lvl_s1),
		.delay(dly_s1),
		.cur  (cur_cnt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			hit_s1      <= 1'b0;
			rvld_s1     <= 1'b0;
			entry_vld_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1  <= 1'b1;
				hit_s1  <= commit && res.we && (idx_s1 == in_idx);
				rvld_s1 <= entry_vld_q[in_idx];
			end else if (commit) begin
				vld_s1 <= 1'b0;
			end
			if (commit && res.we) begin
				entry_vld_q[idx_s1] <= 1'b1;
			end
			if (advance) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= s_tuser;
			idx_s1  <= in_idx;
			lvl_s1  <= in_level;
			dly_s1  <= in_delay;
			fwd_s1  <= res.cnt;
		end
		if (commit) begin
			out_q <= res.out;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_q};

endmodule

>>> design/stb_checker.sv
`include "soft_timer_bank_assert.svh"

module stb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// result held while stalled
	`STB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`STB_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
	// pad bits of a result stay zero
	`STB_ASSERT_ALWAYS(a_out_pad, !m_tvalid || (m_tdata[7:1] == 7'd0))
	// an empty output register never blocks requests
	`STB_ASSERT_ALWAYS(a_in_free, m_tvalid || s_tready)

endmodule

bind soft_timer_bank stb_checker u_stb_checker (.*);

>>> sim/tb.sv
module tb;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int N_RANDOM = 1500;
	localparam int CYC_LIMIT = 200000;
	localparam int IDLE_PCT = 27;
	localparam int QUIET_FROM = 1000;
	localparam int QUIET_TO = 1600;

	typedef struct {
		logic [1:0]  kind;
		logic [5:0]  idx;
		logic        lvl;
		logic [15:0] dly;
		logic        hold;
	} tick_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	tick_req_t   tick_reqs[$];
	logic        timer_out_due[$];
	logic [15:0] timer_cnt [stb_pkg::NUM_TIMERS];
	logic        req_taken = 1'b0;
	int          errors = 0;
	int          cyc = 0;

	soft_timer_bank u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// one tick of one timer, updates the local copy of the counts
	function automatic logic tick_timer(input logic [1:0] k, input logic [5:0] i,
		input logic l, input logic [15:0] d);
		logic [15:0] c;
		logic        o;
		c = timer_cnt[i];
		o = 1'b0;
		case (k)
			stb_pkg::KIND_ON_DELAY: begin
				if (!l)
					c = '0;
				else if (c >= d)
					o = 1'b1;
				else
					c = c + 16'd1;
			end
			stb_pkg::KIND_OFF_DELAY: begin
				if (l) begin
					c = d;
					o = 1'b1;
				end else if (c != 16'd0) begin
					o = 1'b1;
					if (c < d)
						c = c - 16'd1;
					else if (d == 16'd0)
						c = '0;
					else
						c = d - 16'd1;
				end
			end
			stb_pkg::KIND_PERIODIC: begin
				if (c != 16'd0) begin
					c = c - 16'd1;
				end else begin
					c = d;
					o = 1'b1;
				end
			end
			default: ;
		endcase
		timer_cnt[i] = c;
		return o;
	endfunction

	task automatic add_tick(input logic [1:0] k, input logic [5:0] i, input logic l,
		input logic [15:0] d, input logic h);
		tick_req_t r;
		r.kind = k;
		r.idx = i;
		r.lvl = l;
		r.dly = d;
		r.hold = h;
		tick_reqs.push_back(r);
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYC_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin : drive_req
		logic      quiet;
		logic      vld;
		tick_req_t nxt;
		if (arst_n) begin
			quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);
			m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
			if (!s_tvalid || req_taken) begin
				vld = 1'b0;
				if (tick_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)
					&& !(tick_reqs[0].hold && timer_out_due.size() != 0)) begin
					nxt = tick_reqs.pop_front();
					vld = 1'b1;
					s_tdata <= {1'b0, nxt.dly, nxt.lvl, nxt.idx};
					s_tuser <= nxt.kind;
				end
				s_tvalid <= vld;
			end
		end
	end

	// predict on each request, check each result
	always @(posedge clk) begin : watch
		logic want;
		if (arst_n) begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				timer_out_due.push_back(tick_timer(s_tuser, s_tdata[5:0], s_tdata[6],
					s_tdata[22:7]));
			if (m_tvalid && m_tready) begin
				if (timer_out_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, actual %h", $time, m_tdata);
				end else begin
					want = timer_out_due.pop_front();
					if (m_tdata !== {7'b0, want}) begin
						errors++;
						$display("%0t: result mismatch, expected %h actual %h",
							$time, {7'b0, want}, m_tdata);
					end
				end
			end
		end
	end

	initial begin : stimulus
		int          r;
		int          len;
		int          n;
		logic [1:0]  k;
		logic [5:0]  i;
		logic        l;
		logic [15:0] d;

		foreach (timer_cnt[j])
			timer_cnt[j] = '0;

		// zero delay, counting up, clear on low, widest values
		add_tick(stb_pkg::KIND_ON_DELAY, 6'd0, 1'b1, 16'd0, 1'b0);
		add_tick(stb_pkg::KIND_ON_DELAY, 6'd1, 1'b1, 16'd2, 1'b0);
		add_tick(stb_pkg::KIND_ON_DELAY, 6'd1, 1'b1, 16'd2, 1'b0);
		add_tick(stb_pkg::KIND_ON_DELAY, 6'd1, 1'b1, 16'd2, 1'b0);
		add_tick(stb_pkg::KIND_ON_DELAY, 6'd1, 1'b0, 16'd2, 1'b0);
		add_tick(stb_pkg::KIND_ON_DELAY, 6'd63, 1'b1, 16'hffff, 1'b0);
		// off-delay run-down to zero
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd2, 1'b1, 16'd3, 1'b0);
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd2, 1'b0, 16'd3, 1'b0);
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd2, 1'b0, 16'd3, 1'b0);
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd2, 1'b0, 16'd3, 1'b0);
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd2, 1'b0, 16'd3, 1'b0);
		// count above delay, then zero delay with count pending
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd3, 1'b1, 16'd5, 1'b0);
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd3, 1'b0, 16'd2, 1'b0);
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd3, 1'b1, 16'd5, 1'b0);
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd3, 1'b0, 16'd0, 1'b0);
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd3, 1'b0, 16'd0, 1'b0);
		// periodic reload and pulse
		add_tick(stb_pkg::KIND_PERIODIC, 6'd4, 1'b0, 16'd2, 1'b0);
		add_tick(stb_pkg::KIND_PERIODIC, 6'd4, 1'b1, 16'd2, 1'b0);
		add_tick(stb_pkg::KIND_PERIODIC, 6'd4, 1'b0, 16'd2, 1'b0);
		add_tick(stb_pkg::KIND_PERIODIC, 6'd4, 1'b1, 16'd2, 1'b0);
		add_tick(stb_pkg::KIND_PERIODIC, 6'd62, 1'b1, 16'hffff, 1'b0);
		add_tick(stb_pkg::KIND_PERIODIC, 6'd62, 1'b0, 16'd0, 1'b0);
		// unused kind leaves the timer alone
		add_tick(KIND_SPARE, 6'd5, 1'b1, 16'hffff, 1'b0);
		add_tick(KIND_SPARE, 6'd62, 1'b0, 16'd0, 1'b0);
		add_tick(stb_pkg::KIND_OFF_DELAY, 6'd61, 1'b1, 16'hffff, 1'b0);

		n = 0;
		while (n < N_RANDOM) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				d = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
				add_tick(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
					1'($urandom_range(0, 1)), d, n == 0 || n == 800);
				n++;
			end else begin
				// burst of ticks on one timer in one mode
				i = 6'($urandom_range(0, 63));
				k = 2'($urandom_range(0, 2));
				d = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
				len = $urandom_range(2, 12);
				for (int j = 0; j < len; j++) begin
					case (k)
						stb_pkg::KIND_ON_DELAY: l = ($urandom_range(0, 9) != 0);
						stb_pkg::KIND_OFF_DELAY: l = (j == 0) || ($urandom_range(0, 99) < 15);
						default: l = 1'($urandom_range(0, 1));
					endcase
					if ($urandom_range(0, 9) == 0)
						d = 16'($urandom_range(0, 6));
					add_tick(k, i, l, d, n == 0 || n == 800);
					n++;
				end
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (tick_reqs.size() != 0 || s_tvalid)
			@(negedge clk);
		while (timer_out_due.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
